// File: hdl/wpf_pkg.sv
package wpf_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam logic [31:0] SPEED_RST = 32'h0001_0000;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_PLAY  = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_PAUSE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_SPEED   = 2'd0,
		REG_LOOP    = 2'd1,
		REG_LINK    = 2'd2,
		REG_REVERSE = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_TK_MUL,
		ST_TK_TRANS,
		ST_DIFF,
		ST_SQ,
		ST_SQRT,
		ST_CMP,
		ST_FROM,
		ST_SH_LO,
		ST_SH_HI,
		ST_SH_SUM,
		ST_DIV,
		ST_APPLY,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} point_t;

endpackage

// File: hdl/waypoint_path_follower_top.sv
// Add point, pause and an idle tick go straight to ST_FIN; play loads point 0 first on restart.
// A moving tick scales the time step, then for each segment takes the distance (33-step
// square root) and walks on while it is shorter than what remains, then makes the final
// move (32-step divide per axis); running off an open end loads the end point instead.
// One request is worked on at a time; the next is taken once the result is registered.
// Reset clears control state, configuration registers and position; the waypoint
// memory is not cleared, as entries at or beyond the fill count read as zero.
module waypoint_path_follower_top #(
	parameter int MAX_POINTS = wpf_pkg::MAX_POINTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [3:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [1:0]                          cmd,
	input  logic signed [31:0]                  point_x,
	input  logic signed [31:0]                  point_y,
	input  logic signed [31:0]                  point_z,
	input  logic [31:0]                         time_step,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic signed [31:0]                  pos_x,
	output logic signed [31:0]                  pos_y,
	output logic signed [31:0]                  pos_z,
	output logic                                ended,
	output logic                                rejected,
	output logic                                walk_overflow,
	output logic [$clog2(MAX_POINTS+1)-1:0]     count_of_points
);

	localparam int IW = $clog2(MAX_POINTS + 1);
	localparam int AW = $clog2(MAX_POINTS);
	localparam int SW = $clog2(2 * MAX_POINTS + 1);
	localparam logic [SW-1:0] WALK_LIMIT = SW'(2 * MAX_POINTS);
	localparam logic [IW-1:0] MAX_CNT = IW'(MAX_POINTS);

	// configuration
	logic [31:0] speed_q;
	logic        loop_q, link_q, rev_q;

	// control state
	wpf_pkg::state_t state_q, state_d;
	logic [IW-1:0] count_q, prev_q, next_q;
	logic          ended_q, paused_q, started_q;
	logic [SW-1:0] steps_q;
	logic [1:0]    axis_q;
	logic          rej_q, ovf_q;
	logic [31:0]   cur_q [3];

	// datapath
	logic [31:0]        ts_q;
	logic [47:0]        trans_q;
	logic signed [32:0] d_q [3];
	logic [63:0]        mul_q;
	logic [65:0]        acc_q;
	logic [35:0]        sq_rem_q;
	logic [32:0]        root_q;
	logic [5:0]         it_q;
	logic [55:0]        p0_q;
	logic [33:0]        dv_rem_q;
	logic [31:0]        dv_lo_q;
	logic [31:0]        dv_quo_q;

	// waypoint memory
	wpf_pkg::point_t mem [MAX_POINTS];
	wpf_pkg::point_t rd_q;
	logic            rz_q;
	logic            wr_en, rd_en;
	logic [IW-1:0]   rd_idx;

	// output register
	logic        res_valid_q;
	logic [31:0] out_x_q, out_y_q, out_z_q;
	logic        out_end_q, out_rej_q, out_ovf_q;
	logic [IW-1:0] out_cnt_q;

	logic        accept, cfg_wr;
	logic [31:0] mul_a, mul_b;
	logic [31:0] pt [3];
	logic [31:0] mag_ax;
	logic [IW-1:0] to_idx;

	// walk step
	logic          end_hit;
	logic [IW-1:0] end_idx, np, nn, nfrom;
	logic [IW:0]   p1, n1;

	// combinational arithmetic
	logic [35:0] sq_rem_n, sq_trial;
	logic [33:0] dv_rem_n;
	logic [79:0] full_prod;
	logic [31:0] q_signed;

	assign pready    = 1'b1;
	assign req_stall = (state_q != wpf_pkg::ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign cfg_wr    = psel && penable && pwrite;

	assign res_valid       = res_valid_q;
	assign pos_x           = out_x_q;
	assign pos_y           = out_y_q;
	assign pos_z           = out_z_q;
	assign ended           = out_end_q;
	assign rejected        = out_rej_q;
	assign walk_overflow   = out_ovf_q;
	assign count_of_points = out_cnt_q;

	always_comb begin
		unique case (wpf_pkg::reg_idx_t'(paddr[3:2]))
			wpf_pkg::REG_SPEED:   prdata = speed_q;
			wpf_pkg::REG_LOOP:    prdata = {31'd0, loop_q};
			wpf_pkg::REG_LINK:    prdata = {31'd0, link_q};
			wpf_pkg::REG_REVERSE: prdata = {31'd0, rev_q};
			default:              prdata = 32'd0;
		endcase
	end

	// entries at or beyond the fill count read as zero
	assign pt[0] = rz_q ? 32'd0 : rd_q.x;
	assign pt[1] = rz_q ? 32'd0 : rd_q.y;
	assign pt[2] = rz_q ? 32'd0 : rd_q.z;

	assign to_idx = rev_q ? prev_q : next_q;
	assign mag_ax = d_q[axis_q][32] ? 32'(-d_q[axis_q]) : d_q[axis_q][31:0];

	// index update for crossing into the next segment
	always_comb begin
		end_hit = 1'b0;
		end_idx = '0;
		p1 = {1'b0, prev_q} + 1'b1;
		n1 = {1'b0, next_q} + 1'b1;
		np = prev_q;
		nn = next_q;
		if (!rev_q) begin
			if (n1 >= {1'b0, count_q}) begin
				if (!loop_q) begin
					// indices still step on past the last point
					end_hit = 1'b1;
					end_idx = count_q - 1'b1;
					np = p1[IW-1:0];
					nn = n1[IW-1:0];
				end else if (link_q) begin
					np = p1[IW-1:0];
					nn = '0;
				end else begin
					np = '0;
					nn = IW'(1);
				end
			end else if (p1 >= {1'b0, count_q}) begin
				np = '0;
				nn = n1[IW-1:0];
			end else begin
				np = p1[IW-1:0];
				nn = n1[IW-1:0];
			end
			nfrom = np;
		end else begin
			if (prev_q == '0) begin
				if (!loop_q) begin
					end_hit = 1'b1;
				end else if (link_q) begin
					np = count_q - 1'b1;
					nn = '0;
				end else begin
					nn = count_q - 1'b1;
					np = count_q - IW'(2);
				end
			end else if (next_q == '0) begin
				nn = count_q - 1'b1;
				np = prev_q - 1'b1;
			end else begin
				np = prev_q - 1'b1;
				nn = next_q - 1'b1;
			end
			nfrom = nn;
		end
	end

	always_comb begin
		sq_rem_n  = {sq_rem_q[33:0], acc_q[65:64]};
		sq_trial  = {1'b0, root_q, 2'b01};
		dv_rem_n  = {dv_rem_q[32:0], dv_lo_q[31]};
		full_prod = {24'd0, p0_q} + {mul_q[55:0], 24'd0};
		q_signed  = d_q[axis_q][32] ? (~dv_quo_q + 32'd1) : dv_quo_q;
	end

	always_comb begin
		state_d = state_q;
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		rd_idx  = '0;
		mul_a   = mag_ax;
		mul_b   = mag_ax;
		unique case (state_q)
			wpf_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = wpf_pkg::ST_FIN;
					unique case (wpf_pkg::cmd_t'(cmd))
						wpf_pkg::CMD_ADD: begin
							wr_en = !((loop_q && started_q) || count_q >= MAX_CNT);
						end
						wpf_pkg::CMD_PLAY: begin
							if (!paused_q && count_q != '0) begin
								rd_en   = 1'b1;
								state_d = wpf_pkg::ST_LOAD;
							end
						end
						wpf_pkg::CMD_TICK: begin
							if (count_q >= IW'(2) && !ended_q && !paused_q)
								state_d = wpf_pkg::ST_TK_MUL;
						end
						wpf_pkg::CMD_PAUSE: ;
						default: ;
					endcase
				end
			end
			wpf_pkg::ST_LOAD: state_d = wpf_pkg::ST_FIN;
			wpf_pkg::ST_TK_MUL: begin
				mul_a   = speed_q;
				mul_b   = ts_q;
				state_d = wpf_pkg::ST_TK_TRANS;
			end
			wpf_pkg::ST_TK_TRANS: begin
				rd_en   = 1'b1;
				rd_idx  = to_idx;
				state_d = wpf_pkg::ST_DIFF;
			end
			wpf_pkg::ST_DIFF: state_d = wpf_pkg::ST_SQ;
			wpf_pkg::ST_SQ: begin
				if (it_q == 6'd3)
					state_d = wpf_pkg::ST_SQRT;
			end
			wpf_pkg::ST_SQRT: begin
				if (it_q == 6'd32)
					state_d = wpf_pkg::ST_CMP;
			end
			wpf_pkg::ST_CMP: begin
				if ({15'd0, root_q} < trans_q) begin
					if (steps_q == WALK_LIMIT) begin
						state_d = wpf_pkg::ST_FIN;
					end else if (end_hit) begin
						rd_en   = 1'b1;
						rd_idx  = end_idx;
						state_d = wpf_pkg::ST_LOAD;
					end else begin
						rd_en   = 1'b1;
						rd_idx  = nfrom;
						state_d = wpf_pkg::ST_FROM;
					end
				end else if (root_q == '0) begin
					state_d = wpf_pkg::ST_FIN;
				end else begin
					state_d = wpf_pkg::ST_SH_LO;
				end
			end
			wpf_pkg::ST_FROM: begin
				rd_en   = 1'b1;
				rd_idx  = to_idx;
				state_d = wpf_pkg::ST_DIFF;
			end
			wpf_pkg::ST_SH_LO: begin
				mul_b   = {8'd0, trans_q[23:0]};
				state_d = wpf_pkg::ST_SH_HI;
			end
			wpf_pkg::ST_SH_HI: begin
				mul_b   = {8'd0, trans_q[47:24]};
				state_d = wpf_pkg::ST_SH_SUM;
			end
			wpf_pkg::ST_SH_SUM: state_d = wpf_pkg::ST_DIV;
			wpf_pkg::ST_DIV: begin
				if (it_q == 6'd31)
					state_d = wpf_pkg::ST_APPLY;
			end
			wpf_pkg::ST_APPLY: begin
				state_d = (axis_q == 2'd2) ? wpf_pkg::ST_FIN : wpf_pkg::ST_SH_LO;
			end
			wpf_pkg::ST_FIN: begin
				if (!res_valid_q || !res_stall)
					state_d = wpf_pkg::ST_IDLE;
			end
			default: state_d = wpf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[count_q[AW-1:0]] <= '{x: point_x, y: point_y, z: point_z};
		if (rd_en) begin
			rd_q <= mem[rd_idx[AW-1:0]];
			rz_q <= (rd_idx >= count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wpf_pkg::ST_IDLE;
			speed_q     <= wpf_pkg::SPEED_RST;
			loop_q      <= 1'b0;
			link_q      <= 1'b0;
			rev_q       <= 1'b0;
			count_q     <= '0;
			prev_q      <= '0;
			next_q      <= '0;
			ended_q     <= 1'b0;
			paused_q    <= 1'b0;
			started_q   <= 1'b0;
			steps_q     <= '0;
			axis_q      <= '0;
			rej_q       <= 1'b0;
			ovf_q       <= 1'b0;
			cur_q       <= '{default: 32'd0};
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				unique case (wpf_pkg::reg_idx_t'(paddr[3:2]))
					wpf_pkg::REG_SPEED:   speed_q <= pwdata;
					wpf_pkg::REG_LOOP:    loop_q  <= pwdata[0];
					wpf_pkg::REG_LINK:    link_q  <= pwdata[0];
					wpf_pkg::REG_REVERSE: rev_q   <= pwdata[0];
					default: ;
				endcase
			end
			if (state_q == wpf_pkg::ST_FIN && (!res_valid_q || !res_stall))
				res_valid_q <= 1'b1;
			else if (res_valid_q && !res_stall)
				res_valid_q <= 1'b0;
			unique case (state_q)
				wpf_pkg::ST_IDLE: begin
					if (accept) begin
						rej_q <= (wpf_pkg::cmd_t'(cmd) == wpf_pkg::CMD_ADD) && !wr_en;
						ovf_q <= 1'b0;
						unique case (wpf_pkg::cmd_t'(cmd))
							wpf_pkg::CMD_ADD: begin
								if (wr_en) begin
									count_q <= count_q + 1'b1;
									if (count_q == '0) begin
										prev_q <= '0;
										cur_q  <= '{point_x, point_y, point_z};
										if (ended_q && !rev_q)
											next_q <= IW'(1);
									end else if (count_q == IW'(1) || (ended_q && !rev_q)) begin
										next_q <= prev_q + 1'b1;
									end
									if (ended_q && !rev_q)
										ended_q <= 1'b0;
								end
							end
							wpf_pkg::CMD_PLAY: begin
								if (paused_q) begin
									paused_q <= 1'b0;
								end else begin
									ended_q <= 1'b0;
									prev_q  <= '0;
									next_q  <= IW'(1);
								end
							end
							wpf_pkg::CMD_TICK: begin
								started_q <= 1'b1;
								steps_q   <= '0;
							end
							wpf_pkg::CMD_PAUSE: paused_q <= 1'b1;
							default: ;
						endcase
					end
				end
				wpf_pkg::ST_LOAD: cur_q <= '{pt[0], pt[1], pt[2]};
				wpf_pkg::ST_FROM: cur_q <= '{pt[0], pt[1], pt[2]};
				wpf_pkg::ST_DIFF: axis_q <= '0;
				wpf_pkg::ST_SQ: begin
					// the multiplier squares axis it_q
					if (it_q < 6'd2)
						axis_q <= axis_q + 1'b1;
				end
				wpf_pkg::ST_CMP: begin
					axis_q <= '0;
					if ({15'd0, root_q} < trans_q) begin
						if (steps_q == WALK_LIMIT) begin
							ovf_q <= 1'b1;
						end else begin
							steps_q <= steps_q + 1'b1;
							prev_q  <= np;
							next_q  <= nn;
							if (end_hit)
								ended_q <= 1'b1;
						end
					end
				end
				wpf_pkg::ST_APPLY: begin
					cur_q[axis_q] <= cur_q[axis_q] + q_signed;
					axis_q        <= axis_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		mul_q <= 64'(mul_a) * 64'(mul_b);
		unique case (state_q)
			wpf_pkg::ST_IDLE: ts_q <= time_step;
			wpf_pkg::ST_TK_TRANS: trans_q <= mul_q[63:16];
			wpf_pkg::ST_DIFF: begin
				d_q[0] <= {pt[0][31], pt[0]} - {cur_q[0][31], cur_q[0]};
				d_q[1] <= {pt[1][31], pt[1]} - {cur_q[1][31], cur_q[1]};
				d_q[2] <= {pt[2][31], pt[2]} - {cur_q[2][31], cur_q[2]};
				it_q   <= '0;
				acc_q  <= '0;
			end
			wpf_pkg::ST_SQ: begin
				// axis it_q is squared while the previous square is summed
				if (it_q != 6'd0)
					acc_q <= acc_q + {2'd0, mul_q};
				if (it_q == 6'd3) begin
					sq_rem_q <= '0;
					root_q   <= '0;
					it_q     <= '0;
				end else begin
					it_q <= it_q + 1'b1;
				end
			end
			wpf_pkg::ST_SQRT: begin
				if (sq_rem_n >= sq_trial) begin
					sq_rem_q <= sq_rem_n - sq_trial;
					root_q   <= {root_q[31:0], 1'b1};
				end else begin
					sq_rem_q <= sq_rem_n;
					root_q   <= {root_q[31:0], 1'b0};
				end
				acc_q <= {acc_q[63:0], 2'b00};
				it_q  <= it_q + 1'b1;
			end
			wpf_pkg::ST_CMP: begin
				if ({15'd0, root_q} < trans_q)
					trans_q <= trans_q - {15'd0, root_q};
			end
			wpf_pkg::ST_SH_HI: p0_q <= mul_q[55:0];
			wpf_pkg::ST_SH_SUM: begin
				// quotient fits 32 bits, so the upper part is below the divisor
				dv_rem_q <= full_prod[65:32];
				dv_lo_q  <= full_prod[31:0];
				dv_quo_q <= '0;
				it_q     <= '0;
			end
			wpf_pkg::ST_DIV: begin
				if (dv_rem_n >= {1'b0, root_q}) begin
					dv_rem_q <= dv_rem_n - {1'b0, root_q};
					dv_quo_q <= {dv_quo_q[30:0], 1'b1};
				end else begin
					dv_rem_q <= dv_rem_n;
					dv_quo_q <= {dv_quo_q[30:0], 1'b0};
				end
				dv_lo_q <= {dv_lo_q[30:0], 1'b0};
				it_q    <= it_q + 1'b1;
			end
			wpf_pkg::ST_FIN: begin
				if (!res_valid_q || !res_stall) begin
					out_x_q   <= cur_q[0];
					out_y_q   <= cur_q[1];
					out_z_q   <= cur_q[2];
					out_end_q <= ended_q;
					out_rej_q <= rej_q;
					out_ovf_q <= ovf_q;
					out_cnt_q <= count_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: hdl/wpf_checker.sv
module wpf_checker #(
	parameter int MAX_POINTS = wpf_pkg::MAX_POINTS_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            res_valid,
	input logic                            res_stall,
	input logic [31:0]                     pos_x,
	input logic                            ended,
	input logic                            rejected,
	input logic                            walk_overflow,
	input logic [$clog2(MAX_POINTS+1)-1:0] count_of_points
);

	localparam int IW = $clog2(MAX_POINTS + 1);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(pos_x))
		else $error("stalled result dropped or changed");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> count_of_points <= IW'(MAX_POINTS))
		else $error("waypoint count beyond capacity");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(rejected && walk_overflow))
		else $error("refused add and walk limit in one result");

	a_ovf_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && walk_overflow |-> !ended)
		else $error("walk limit reported on an ended path");

endmodule

bind waypoint_path_follower_top wpf_checker #(.MAX_POINTS(MAX_POINTS)) u_wpf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (res_valid),
	.res_stall       (res_stall),
	.pos_x           (pos_x),
	.ended           (ended),
	.rejected        (rejected),
	.walk_overflow   (walk_overflow),
	.count_of_points (count_of_points)
);
